>>> design/mip_pkg.sv
// ---------------------------------------------------------------------------
// mip_pkg: shared types and constants of the maximum intensity projection
// Holds the request payload types of both streams and the codes of the
// configuration registers and the projection axes.
// ---------------------------------------------------------------------------
package mip_pkg;

    // Widths fixed by the stream and register formats.
    localparam int VOXEL_W = 16;
    localparam int COORD_W = 8;
    localparam int SIZE_W  = 9;
    localparam int AXIS_W  = 2;
    localparam int CFG_IDX_W = 2;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] REG_SIZE_X = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SIZE_Y = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_SIZE_Z = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_AXIS   = 2'd3;

    // Projection axis codes; the unused code behaves as the z axis.
    localparam logic [AXIS_W-1:0] AXIS_X = 2'd0;
    localparam logic [AXIS_W-1:0] AXIS_Y = 2'd1;
    localparam logic [AXIS_W-1:0] AXIS_Z = 2'd2;

    // Register reset values.
    localparam logic [SIZE_W-1:0] SIZE_RESET = 9'd256;

    typedef struct packed {
        logic [VOXEL_W-1:0] voxel_value;
        logic               volume_start;
    } t_voxel;

    typedef struct packed {
        logic [COORD_W-1:0] plane_col;
        logic [COORD_W-1:0] plane_row;
        logic [VOXEL_W-1:0] max_value;
        logic               final_value;
    } t_proj;

endpackage

>>> design/mip_voxel_if.sv
// ---------------------------------------------------------------------------
// mip_voxel_if: voxel request stream
// Valid/ready channel that carries one voxel and its volume start flag.
// ---------------------------------------------------------------------------
interface mip_voxel_if
    import mip_pkg::*;
();
    logic   valid;
    logic   ready;
    t_voxel payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

>>> design/mip_proj_if.sv
// ---------------------------------------------------------------------------
// mip_proj_if: projection result stream
// Valid/ready channel that carries one updated plane pixel.
// ---------------------------------------------------------------------------
interface mip_proj_if
    import mip_pkg::*;
();
    logic  valid;
    logic  ready;
    t_proj payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

>>> design/max_intensity_projection.sv
// ---------------------------------------------------------------------------
// max_intensity_projection: streaming maximum intensity projection
// Collapses a raster-ordered voxel volume along one axis into a plane of
// running maxima held in an on-chip memory.
// ---------------------------------------------------------------------------
// Usage. Voxels arrive on i_vox in raster order, x fastest, then y, then z.
// A request with volume_start set places that voxel at the origin; after the
// last voxel of a volume the counters return to the origin by themselves.
// Every voxel request gives exactly one result request on o_proj: the plane
// pixel it touched, the running maximum there, and a flag set on the last
// slice along the projection axis.
// The user must write sizes and the axis through the plain write port only
// while the block is idle; the block does not enforce it. A size of 0 counts
// as 1, a size above MAX_DIM as MAX_DIM. An accepted voxel enters the update
// stage, then the output register once it is free. Throughput: one voxel per
// cycle while the receiver keeps up, held by the read-modify-write of the
// plane memory, which reads on accept and writes as the item leaves the
// update stage; a back-to-back update of the same pixel is served by a
// forwarding register. No clearing is needed: a first slice overwrites the entry.
// Reset clears the position counters, the pipeline and the output valid and
// loads the register defaults (sizes 256, z projection).
// When the receiver stalls, the result stays in the output register, the
// update stage holds its item and input ready falls once both are full.
// ---------------------------------------------------------------------------
module max_intensity_projection
    import mip_pkg::*;
#(
    parameter int MAX_DIM    = 256,
    parameter int PIXEL_BITS = 16
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [SIZE_W-1:0]    i_cfg_data,
    mip_voxel_if.sink            i_vox,
    mip_proj_if.source           o_proj
);

    // Position counter width, size arithmetic width and plane address width.
    localparam int DW = $clog2(MAX_DIM);
    localparam int CW = (DW + 1 > SIZE_W + 1) ? DW + 1 : SIZE_W + 1;
    localparam int PLANE_DEPTH = MAX_DIM * MAX_DIM;
    localparam int AW = $clog2(PLANE_DEPTH);

    // Configuration registers.
    logic [SIZE_W-1:0] r_size_x, r_size_y, r_size_z;
    logic [AXIS_W-1:0] r_axis;

    // Position of the next voxel.
    logic [DW-1:0] r_pos_x, r_pos_y, r_pos_z;
    logic [DW-1:0] n_pos_x, n_pos_y, n_pos_z;

    // Update stage: the item whose memory read is in flight.
    logic                  r_s1_v;
    logic [AW-1:0]         r_s1_addr;
    logic [PIXEL_BITS-1:0] r_s1_voxel;
    logic                  r_s1_first;
    logic                  r_s1_final;
    logic [DW-1:0]         r_s1_col, r_s1_row;
    logic [PIXEL_BITS-1:0] r_rd;
    logic                  r_fwd_hit;
    logic [PIXEL_BITS-1:0] r_fwd_val;

    // Output register.
    logic  r_o_v;
    t_proj r_o;

    // Plane memory, one read and one write port.
    logic [PIXEL_BITS-1:0] r_plane [PLANE_DEPTH];

    logic                  acc, s1_fire;
    logic [CW-1:0]         sx, sy, sz, slices;
    logic [DW-1:0]         bx, by, bz, col, row, slice;
    logic [AW-1:0]         addr;
    logic [CW-1:0]         x1, y1, z1;
    logic [PIXEL_BITS-1:0] vox, base, s1_val;

    // Effective size: zero counts as one, oversize is clamped.
    function automatic logic [CW-1:0] eff_size(input logic [SIZE_W-1:0] s);
        logic [CW-1:0] w;
        w = CW'(s);
        if (w == '0) begin
            return CW'(1);
        end else if (w > CW'(MAX_DIM)) begin
            return CW'(MAX_DIM);
        end
        return w;
    endfunction

    assign s1_fire = r_s1_v && (!r_o_v || o_proj.ready);
    assign i_vox.ready = !r_s1_v || s1_fire;
    assign acc = i_vox.valid && i_vox.ready;

    assign sx = eff_size(r_size_x);
    assign sy = eff_size(r_size_y);
    assign sz = eff_size(r_size_z);

    // A volume start places this voxel at the origin.
    assign bx = i_vox.payload.volume_start ? '0 : r_pos_x;
    assign by = i_vox.payload.volume_start ? '0 : r_pos_y;
    assign bz = i_vox.payload.volume_start ? '0 : r_pos_z;

    // Map the position onto the plane and the slice index.
    always_comb begin
        case (r_axis)
            AXIS_X: begin
                col = bz; row = by; slice = bx; slices = sx;
            end
            AXIS_Y: begin
                col = bx; row = bz; slice = by; slices = sy;
            end
            default: begin
                col = bx; row = by; slice = bz; slices = sz;
            end
        endcase
    end

    assign addr = AW'(row) * AW'(MAX_DIM) + AW'(col);
    assign vox  = PIXEL_BITS'(i_vox.payload.voxel_value);

    // Raster advance; counters at or past their size wrap to zero.
    always_comb begin
        x1 = CW'(bx) + CW'(1);
        y1 = CW'(by) + CW'(1);
        z1 = CW'(bz) + CW'(1);
        n_pos_x = x1[DW-1:0];
        n_pos_y = by;
        n_pos_z = bz;
        if (x1 >= sx) begin
            n_pos_x = '0;
            n_pos_y = y1[DW-1:0];
            if (y1 >= sy) begin
                n_pos_y = '0;
                n_pos_z = z1[DW-1:0];
                if (z1 >= sz) begin
                    n_pos_z = '0;
                end
            end
        end
    end

    // The read issued together with a write to the same pixel sees the old
    // entry, so the freshly written value is taken from the forward register.
    assign base   = r_fwd_hit ? r_fwd_val : r_rd;
    assign s1_val = r_s1_first ? r_s1_voxel
                  : ((r_s1_voxel > base) ? r_s1_voxel : base);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_size_x  <= SIZE_RESET;
            r_size_y  <= SIZE_RESET;
            r_size_z  <= SIZE_RESET;
            r_axis    <= AXIS_Z;
            r_pos_x   <= '0;
            r_pos_y   <= '0;
            r_pos_z   <= '0;
            r_s1_v    <= 1'b0;
            r_fwd_hit <= 1'b0;
            r_o_v     <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    REG_SIZE_X: r_size_x <= i_cfg_data;
                    REG_SIZE_Y: r_size_y <= i_cfg_data;
                    REG_SIZE_Z: r_size_z <= i_cfg_data;
                    REG_AXIS:   r_axis   <= i_cfg_data[AXIS_W-1:0];
                    default: ;
                endcase
            end
            if (acc) begin
                r_pos_x   <= n_pos_x;
                r_pos_y   <= n_pos_y;
                r_pos_z   <= n_pos_z;
                r_fwd_hit <= s1_fire && (r_s1_addr == addr);
                r_s1_v    <= 1'b1;
            end else if (s1_fire) begin
                r_s1_v <= 1'b0;
            end
            if (s1_fire) begin
                r_o_v <= 1'b1;
            end else if (o_proj.ready) begin
                r_o_v <= 1'b0;
            end
        end
    end

    // Payload registers and the plane memory.
    always_ff @(posedge i_clk) begin
        if (acc) begin
            r_s1_addr  <= addr;
            r_s1_voxel <= vox;
            r_s1_first <= (slice == '0);
            r_s1_final <= (CW'(slice) == slices - CW'(1));
            r_s1_col   <= col;
            r_s1_row   <= row;
            r_rd       <= r_plane[addr];
            r_fwd_val  <= s1_val;
        end
        if (s1_fire) begin
            r_plane[r_s1_addr]  <= s1_val;
            r_o.plane_col   <= COORD_W'(32'(r_s1_col));
            r_o.plane_row   <= COORD_W'(32'(r_s1_row));
            r_o.max_value   <= VOXEL_W'(32'(s1_val));
            r_o.final_value <= r_s1_final;
        end
    end

    assign o_proj.valid   = r_o_v;
    assign o_proj.payload = r_o;

`ifndef ASSERT_OFF
    // An empty update stage never blocks the input.
    a_ready_when_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_s1_v |-> i_vox.ready)
        else $error("input stalled with an empty update stage");

    // A result is never below the voxel that produced it.
    a_max_ge_voxel: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s1_fire |-> (s1_val >= r_s1_voxel))
        else $error("running maximum below the current voxel");

    // An item in the update stage stays there until it moves on.
    a_s1_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s1_v && !s1_fire) |=> (r_s1_v && $stable(r_s1_addr)))
        else $error("stalled update item lost");
`endif

endmodule

>>> tb/mip_check_pkg.sv
// ---------------------------------------------------------------------------
// mip_check_pkg: result prediction for the maximum intensity projection
// Keeps a behavioural copy of the position counters, the registers and the
// plane of running maxima. It predicts the result request of every accepted
// voxel and checks the results in order as they arrive.
// ---------------------------------------------------------------------------
package mip_check_pkg;
    import mip_pkg::*;

    localparam int PLANE_DIM = 256;

    // Index of each volume axis in the position array.
    localparam int DIM_X = 0;
    localparam int DIM_Y = 1;
    localparam int DIM_Z = 2;

    class mip_scoreboard;
        logic [SIZE_W-1:0]  size_reg [3];
        logic [AXIS_W-1:0]  axis_reg;
        int unsigned        pos [3];
        logic [VOXEL_W-1:0] plane_max [PLANE_DIM*PLANE_DIM];
        bit                 plane_seen [PLANE_DIM*PLANE_DIM];
        t_proj              pixel_q [$];
        int unsigned        pixel_count;
        int unsigned        fail_count;

        function new();
            size_reg    = '{SIZE_RESET, SIZE_RESET, SIZE_RESET};
            axis_reg    = AXIS_Z;
            pos         = '{0, 0, 0};
            pixel_count = 0;
            fail_count  = 0;
        endfunction

        function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [SIZE_W-1:0] data);
            case (idx)
                REG_SIZE_X: size_reg[DIM_X] = data;
                REG_SIZE_Y: size_reg[DIM_Y] = data;
                REG_SIZE_Z: size_reg[DIM_Z] = data;
                REG_AXIS:   axis_reg = data[AXIS_W-1:0];
            endcase
        endfunction

        // Size in effect along one axis: zero counts as one, the excess is clipped.
        function int unsigned span(int d);
            if (size_reg[d] == 0)
                return 1;
            if (size_reg[d] > PLANE_DIM)
                return PLANE_DIM;
            return size_reg[d];
        endfunction

        // Which volume axes give the plane column, the plane row and the slice.
        function void axes(output int c, output int r, output int s);
            case (axis_reg)
                AXIS_X: begin
                    c = DIM_Z; r = DIM_Y; s = DIM_X;
                end
                AXIS_Y: begin
                    c = DIM_X; r = DIM_Z; s = DIM_Y;
                end
                default: begin
                    c = DIM_X; r = DIM_Y; s = DIM_Z;
                end
            endcase
        endfunction

        // True when the next voxel, sent without volume start, would read a
        // plane pixel that no first slice has written since reset.
        function bit needs_origin();
            int c, r, s;
            axes(c, r, s);
            return pos[s] != 0 && !plane_seen[pos[r] * PLANE_DIM + pos[c]];
        endfunction

        function void note_voxel(t_voxel v);
            int          c, r, s;
            int unsigned addr;
            t_proj       px;
            if (v.volume_start)
                pos = '{0, 0, 0};
            axes(c, r, s);
            addr = pos[r] * PLANE_DIM + pos[c];
            if (pos[s] == 0 || v.voxel_value > plane_max[addr])
                plane_max[addr] = v.voxel_value;
            plane_seen[addr] = 1'b1;
            px.plane_col   = COORD_W'(pos[c]);
            px.plane_row   = COORD_W'(pos[r]);
            px.max_value   = plane_max[addr];
            px.final_value = (pos[s] == span(s) - 1);
            pixel_q.push_back(px);

            // Raster order: x fastest, a counter past its size returns to zero.
            pos[DIM_X]++;
            if (pos[DIM_X] >= span(DIM_X)) begin
                pos[DIM_X] = 0;
                pos[DIM_Y]++;
                if (pos[DIM_Y] >= span(DIM_Y)) begin
                    pos[DIM_Y] = 0;
                    pos[DIM_Z]++;
                    if (pos[DIM_Z] >= span(DIM_Z))
                        pos[DIM_Z] = 0;
                end
            end
        endfunction

        task check_pixel(t_proj got);
            t_proj want;
            pixel_count++;
            if (pixel_q.size() == 0) begin
                report($sformatf("result %0d arrived with nothing expected", pixel_count));
                return;
            end
            want = pixel_q.pop_front();
            if (got.plane_col !== want.plane_col)
                report($sformatf("result %0d: plane_col %0d, expected %0d",
                                 pixel_count, got.plane_col, want.plane_col));
            if (got.plane_row !== want.plane_row)
                report($sformatf("result %0d: plane_row %0d, expected %0d",
                                 pixel_count, got.plane_row, want.plane_row));
            if (got.max_value !== want.max_value)
                report($sformatf("result %0d: max_value %h, expected %h",
                                 pixel_count, got.max_value, want.max_value));
            if (got.final_value !== want.final_value)
                report($sformatf("result %0d: final_value %b, expected %b",
                                 pixel_count, got.final_value, want.final_value));
        endtask

        task report(string msg);
            if (fail_count < 100)
                $display("mismatch: %s", msg);
            fail_count++;
        endtask
    endclass

endpackage

>>> tb/tb_top.sv
// ---------------------------------------------------------------------------
// tb_top: self-checking testbench of the maximum intensity projection
// A short directed sequence covers every axis, first and last slices and
// out-of-range registers; random volumes of many shapes follow, with random
// idling on both streams and repeated long stalls of the result receiver.
// ---------------------------------------------------------------------------
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import mip_pkg::*;
    import mip_check_pkg::*;

    localparam int CYCLE_LIMIT = 200000;
    localparam int LONG_HOLD   = 64;
    localparam int DRAIN_WAIT  = 4;

    // The fourth axis code, which the block treats as a z projection.
    localparam logic [AXIS_W-1:0] AXIS_SPARE = 2'd3;

    // One phase of the run: the volume geometry and how many voxels it gets.
    typedef struct {
        logic [SIZE_W-1:0] sx;
        logic [SIZE_W-1:0] sy;
        logic [SIZE_W-1:0] sz;
        logic [AXIS_W-1:0] axis;
        int unsigned       voxels;
    } t_shape;

    logic                 i_clk      = 1'b0;
    logic                 i_rst_n    = 1'b0;
    logic                 i_cfg_we   = 1'b0;
    logic [CFG_IDX_W-1:0] i_cfg_idx  = '0;
    logic [SIZE_W-1:0]    i_cfg_data = '0;

    mip_voxel_if vox_if ();
    mip_proj_if  proj_if ();

    mip_scoreboard board = new();

    int unsigned cycle_count = 0;
    bit          send_steady = 1'b0;
    bit          recv_steady = 1'b0;
    bit          long_hold_req = 1'b0;

    max_intensity_projection DUT (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_vox      (vox_if),
        .o_proj     (proj_if)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // Watchdog: a hung handshake ends the run as a failure.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("FAIL max_intensity_projection");
            $finish;
        end
    end

    // Every result request accepted at this edge is checked against the
    // oldest prediction. Values are those from before the edge.
    always @(posedge i_clk) begin
        if (i_rst_n && proj_if.valid && proj_if.ready)
            board.check_pixel(proj_if.payload);
    end

    // Idle cycles before the next request. Now and then a side switches
    // between a steady stretch without gaps and a stretch of random gaps.
    function automatic int unsigned pick_gap(inout bit steady);
        if ($urandom_range(0, 15) == 0)
            steady = !steady;
        return steady ? 0 : $urandom_range(0, 13);
    endfunction

    // Mostly small sizes, with zero and oversized values mixed in.
    function automatic logic [SIZE_W-1:0] random_size();
        case ($urandom_range(0, 7))
            0:       return '0;
            1:       return SIZE_W'($urandom_range(257, 511));
            default: return SIZE_W'($urandom_range(1, 5));
        endcase
    endfunction

    // Offers one voxel request and returns at the edge where it is taken.
    // Valid is left high so that a back-to-back request needs no extra step.
    task automatic send_voxel(input logic [VOXEL_W-1:0] value, input logic start);
        t_voxel      v;
        int unsigned gap;
        // A voxel beyond the first slice must land on a pixel that some first
        // slice has already filled; where none has, it starts a new volume.
        v.voxel_value  = value;
        v.volume_start = start | board.needs_origin();
        gap = pick_gap(send_steady);
        if (gap != 0) begin
            vox_if.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        vox_if.valid   <= 1'b1;
        vox_if.payload <= v;
        do @(posedge i_clk); while (vox_if.ready !== 1'b1);
        board.note_voxel(v);
    endtask

    // Ends a batch of requests and waits for the block to empty, so that the
    // registers may be written safely afterwards.
    task automatic settle();
        vox_if.valid <= 1'b0;
        while (board.pixel_q.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_WAIT) @(posedge i_clk);
    endtask

    // Writes all four registers on consecutive edges. The axis write carries
    // random upper data bits, which the register must ignore.
    task automatic program_volume(input t_shape shape);
        logic [CFG_IDX_W-1:0] reg_index [4];
        logic [SIZE_W-1:0]    reg_value [4];
        reg_index = '{REG_SIZE_X, REG_SIZE_Y, REG_SIZE_Z, REG_AXIS};
        reg_value = '{shape.sx, shape.sy, shape.sz,
                      {(SIZE_W - AXIS_W)'($urandom), shape.axis}};
        for (int i = 0; i < 4; i++) begin
            i_cfg_we   <= 1'b1;
            i_cfg_idx  <= reg_index[i];
            i_cfg_data <= reg_value[i];
            @(posedge i_clk);
            board.write_reg(reg_index[i], reg_value[i]);
        end
        i_cfg_we <= 1'b0;
    endtask

    // Result receiver: draws a stall before every result, and once in a
    // while holds ready low for a long stretch so that the pipeline fills up
    // and the block has to refuse voxel requests.
    initial begin : result_ready
        int unsigned hold;
        proj_if.ready = 1'b0;
        wait (i_rst_n === 1'b1);
        @(posedge i_clk);
        forever begin
            if (long_hold_req) begin
                hold = LONG_HOLD;
                long_hold_req = 1'b0;
            end else begin
                hold = pick_gap(recv_steady);
            end
            if (hold != 0) begin
                proj_if.ready <= 1'b0;
                repeat (hold) @(posedge i_clk);
            end
            proj_if.ready <= 1'b1;
            do @(posedge i_clk); while (proj_if.valid !== 1'b1);
        end
    end

    initial begin : stimulus
        t_shape             plan [6];
        t_shape             shape;
        logic [VOXEL_W-1:0] value;
        logic               start;

        vox_if.valid   = 1'b0;
        vox_if.payload = '0;

        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Register defaults after reset: a 256 cubed volume projected along
        // z, so every voxel here lies on the first slice. The third request
        // restarts at the origin and overwrites pixel (0, 0).
        send_voxel(16'h0000, 1'b0);
        send_voxel(16'hFFFF, 1'b0);
        send_voxel(16'h5555, 1'b1);
        send_voxel(16'hAAAA, 1'b0);
        settle();

        // A 2x2x2 cube along z. The second slice keeps the larger of the two
        // values and is flagged final; after the last voxel the counters
        // wrap round to the origin by themselves.
        program_volume('{9'd2, 9'd2, 9'd2, AXIS_Z, 0});
        send_voxel(16'hFFFF, 1'b0);
        send_voxel(16'h0000, 1'b0);
        send_voxel(16'h8000, 1'b0);
        send_voxel(16'h1234, 1'b0);
        send_voxel(16'h0000, 1'b0);
        send_voxel(16'hFFFF, 1'b0);
        send_voxel(16'h7FFF, 1'b0);
        send_voxel(16'h1235, 1'b0);
        send_voxel(16'h0001, 1'b0);
        send_voxel(16'h0002, 1'b1);
        settle();

        // Projection along x over a two-voxel row, then along y.
        program_volume('{9'd2, 9'd1, 9'd1, AXIS_X, 0});
        send_voxel(16'h0010, 1'b1);
        send_voxel(16'h0008, 1'b0);
        send_voxel(16'h0100, 1'b0);
        send_voxel(16'h0200, 1'b0);
        settle();
        program_volume('{9'd1, 9'd2, 9'd1, AXIS_Y, 0});
        send_voxel(16'h0300, 1'b0);
        send_voxel(16'h0200, 1'b0);
        settle();

        // Sizes of zero and above the maximum, and the spare axis code.
        program_volume('{9'd0, 9'd300, 9'd511, AXIS_SPARE, 0});
        send_voxel(16'hC3C3, 1'b0);
        send_voxel(16'h3C3C, 1'b0);
        settle();

        // Random part. Phases end wherever their count runs out, so the next
        // geometry often takes over in the middle of a volume.
        plan = '{'{9'd3,   9'd2,   9'd4,   AXIS_Z,     15},
                 '{9'd4,   9'd3,   9'd2,   AXIS_X,     15},
                 '{9'd2,   9'd4,   9'd3,   AXIS_Y,     15},
                 '{9'd0,   9'd0,   9'd0,   AXIS_SPARE, 10},
                 '{9'd256, 9'd1,   9'd2,   AXIS_X,     260},
                 '{9'd511, 9'd257, 9'd300, AXIS_Z,     15}};
        for (int n = 0; n < 11; n++) begin
            if (n < 6) begin
                shape = plan[n];
            end else begin
                shape.sx     = random_size();
                shape.sy     = random_size();
                shape.sz     = random_size();
                shape.axis   = AXIS_W'($urandom_range(0, 3));
                shape.voxels = 10;
            end
            program_volume(shape);
            if (n % 3 == 0)
                long_hold_req = 1'b1;
            repeat (shape.voxels) begin
                case ($urandom_range(0, 7))
                    0:       value = '0;
                    1:       value = '1;
                    default: value = VOXEL_W'($urandom);
                endcase
                start = ($urandom_range(0, 31) == 0);
                send_voxel(value, start);
            end
            settle();
        end

        if (board.pixel_q.size() != 0)
            board.report("results still expected at the end of the run");
        if (board.fail_count == 0)
            $display("PASS max_intensity_projection");
        else
            $display("FAIL max_intensity_projection");
        $finish;
    end

endmodule
